// ----- hdl/pks_pkg.sv -----
// shared types and constants of the pose kalman smoother
package pks_pkg;

    localparam int COMPONENTS = 7;
    localparam int FIELD_W    = 32;
    localparam int DATA_W     = COMPONENTS * FIELD_W;
    localparam int NOISE_W    = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int GAIN_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int DIFF_W     = FIELD_W + 1;
    localparam int ACC_W      = DIFF_W + GAIN_W + 1;
    localparam int DEN_W      = FIELD_W + 1;
    localparam int VACC_W     = FIELD_W + GAIN_W;
    localparam int STEP_CNT_W = $clog2(GAIN_W);

    localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET     = NOISE_W'(6554);
    localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RESET = NOISE_W'(65536);
    localparam logic [FIELD_W-1:0] VARIANCE_RESET          = FIELD_W'(65536);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PROCESS_NOISE     = 2'd0,
        REG_MEASUREMENT_NOISE = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic capture;
        logic snap;
        logic prep;
        logic step;
        logic gain_bit;
        logic commit;
    } lane_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

endpackage

// ----- hdl/pks_div.sv -----
// restoring gain divider, one quotient bit per cycle, msb first
module pks_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pks_pkg::div_ctrl_t                ctrl,
    input  logic [pks_pkg::FIELD_W-1:0]       pp,
    input  logic [pks_pkg::NOISE_W-1:0]       r_noise,
    output logic                              q_bit
);
    import pks_pkg::*;

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic             lsb_reg;
    logic [DEN_W-1:0] den_sum;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             ge;

    assign den_sum   = {1'b0, pp} + {{(DEN_W-NOISE_W){1'b0}}, r_noise};
    assign trial     = {rem_reg, lsb_reg};
    assign trial_sub = trial - {1'b0, den_reg};
    assign ge        = trial >= {1'b0, den_reg};
    assign q_bit     = ge && (den_reg != '0);

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            den_reg <= den_sum;
            rem_reg <= {1'b0, pp[FIELD_W-1:1]};
            lsb_reg <= pp[0];
        end else if (ctrl.step) begin
            rem_reg <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            lsb_reg <= 1'b0;
        end
    end

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.load || ctrl.step) |=> (den_reg == '0 || rem_reg < den_reg))
        else $error("divider remainder not below denominator");

    a_den_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load |=> den_reg == $past(den_sum))
        else $error("denominator not captured on load");

    a_den_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.step && !ctrl.load) |=> $stable(den_reg))
        else $error("denominator changed while dividing");

endmodule

// ----- hdl/pks_lane.sv -----
// one estimate lane: difference, serial gain multiply, rounding and saturation
module pks_lane (
    input  logic                                aclk,
    input  pks_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [pks_pkg::FIELD_W-1:0]  meas,
    output logic signed [pks_pkg::FIELD_W-1:0]  est_new
);
    import pks_pkg::*;

    localparam int SUM_W = ACC_W - FRAC_W + 1;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-FIELD_W+1){1'b0}},
                                                   {(FIELD_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {{(SUM_W-FIELD_W+1){1'b1}},
                                                   {(FIELD_W-1){1'b0}}};

    logic signed [FIELD_W-1:0] meas_reg;
    logic signed [FIELD_W-1:0] est_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [SUM_W-1:0]   sum;

    always_comb begin
        acc_next = (acc_reg <<< 1);
        if (ctrl.gain_bit) begin
            acc_next = acc_next + ACC_W'(diff_reg);
        end
    end

    assign acc_rnd = acc_reg + ACC_W'(signed'(1 << (FRAC_W - 1)));
    assign sum     = SUM_W'(est_reg) + SUM_W'(acc_rnd >>> FRAC_W);

    always_comb begin
        if (sum > SUM_MAX) begin
            est_new = 32'sh7fff_ffff;
        end else if (sum < SUM_MIN) begin
            est_new = 32'sh8000_0000;
        end else begin
            est_new = sum[FIELD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            meas_reg <= meas;
        end
        if (ctrl.snap) begin
            est_reg <= meas;
        end else if (ctrl.commit) begin
            est_reg <= est_new;
        end
        if (ctrl.prep) begin
            diff_reg <= DIFF_W'(meas_reg) - DIFF_W'(est_reg);
            acc_reg  <= '0;
        end else if (ctrl.step) begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ----- hdl/pose_kalman_smoother_unit.sv -----
// top level of the pose kalman smoother
// Scalar-covariance Kalman smoother over seven pose lanes (position xyz, quaternion wxyz,
// signed Q16.16). The block takes no new item until the current one leaves the finish step.
// The prep step predicts the variance and forms the lane differences, the load step loads
// the gain divider, the run steps drive the restoring divider one gain bit at a time while
// the seven lane multipliers and the variance multiplier consume each bit as it appears, and
// the finish step rounds, saturates and loads the output register. The finish step waits
// while an earlier result is still not taken. The first item after reset, or any item with
// restart set, loads its measurement as the estimate before filtering; the variance is kept
// across a restart. Configuration writes are read at the next prep or divider load step.
module pose_kalman_smoother_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
    input  logic [pks_pkg::DATA_W-1:0]        s_tdata,
    // restart
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // est_pos_x, est_pos_y, est_pos_z, est_quat_w, est_quat_x, est_quat_y, est_quat_z
    output logic [pks_pkg::DATA_W-1:0]        m_tdata,
    input  logic                              cfg_wen,
    input  logic [pks_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pks_pkg::NOISE_W-1:0]       cfg_wdata
);
    import pks_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LOAD,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                    first_pending_reg;
    logic [NOISE_W-1:0]      process_noise_reg;
    logic [NOISE_W-1:0]      measurement_noise_reg;
    logic [FIELD_W-1:0]      variance_reg;
    logic [FIELD_W-1:0]      variance_next;
    logic [FIELD_W-1:0]      pp_reg;
    logic [FIELD_W:0]        pp_sum;
    logic [VACC_W-1:0]       vacc_reg;
    logic [VACC_W-1:0]       vacc_rnd;
    logic [VACC_W-FRAC_W-1:0] shrink;
    logic                    m_tvalid_reg;
    logic [DATA_W-1:0]       m_tdata_reg;
    logic [DATA_W-1:0]       est_bus;
    logic                    in_xfer;
    logic                    out_free;
    logic                    q_bit;
    div_ctrl_t               div_ctrl;
    lane_ctrl_t              lane_ctrl;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign pp_sum = {1'b0, variance_reg} + {{(FIELD_W+1-NOISE_W){1'b0}}, process_noise_reg};

    assign vacc_rnd      = vacc_reg + VACC_W'(1 << (FRAC_W - 1));
    assign shrink        = vacc_rnd[VACC_W-1:FRAC_W];
    assign variance_next = ({1'b0, shrink} > {{(VACC_W-FRAC_W-FIELD_W+1){1'b0}}, pp_reg})
                         ? '0 : pp_reg - shrink[FIELD_W-1:0];

    assign div_ctrl.load = (state_reg == ST_LOAD);
    assign div_ctrl.step = (state_reg == ST_RUN);

    assign lane_ctrl.capture  = in_xfer;
    assign lane_ctrl.snap     = in_xfer && (first_pending_reg || s_tuser);
    assign lane_ctrl.prep     = (state_reg == ST_PREP);
    assign lane_ctrl.step     = (state_reg == ST_RUN);
    assign lane_ctrl.gain_bit = q_bit;
    assign lane_ctrl.commit   = (state_reg == ST_FINISH) && out_free;

    pks_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .pp      (pp_reg),
        .r_noise (measurement_noise_reg),
        .q_bit   (q_bit)
    );

    for (genvar i = 0; i < COMPONENTS; i++) begin : g_lane
        pks_lane u_lane (
            .aclk    (aclk),
            .ctrl    (lane_ctrl),
            .meas    (s_tdata[i*FIELD_W +: FIELD_W]),
            .est_new (est_bus[i*FIELD_W +: FIELD_W])
        );
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                state_next = ST_RUN;
                cnt_next   = '0;
            end
            ST_RUN: begin
                if (cnt_reg == STEP_CNT_W'(GAIN_W - 1)) begin
                    state_next = ST_FINISH;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= ST_IDLE;
            cnt_reg               <= '0;
            first_pending_reg     <= 1'b1;
            process_noise_reg     <= PROCESS_NOISE_RESET;
            measurement_noise_reg <= MEASUREMENT_NOISE_RESET;
            variance_reg          <= VARIANCE_RESET;
            m_tvalid_reg          <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_wen) begin
                unique case (cfg_addr)
                    REG_PROCESS_NOISE:     process_noise_reg     <= cfg_wdata;
                    REG_MEASUREMENT_NOISE: measurement_noise_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (in_xfer) begin
                first_pending_reg <= 1'b0;
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (lane_ctrl.commit) begin
                m_tvalid_reg <= 1'b1;
                variance_reg <= variance_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PREP) begin
            pp_reg <= pp_sum[FIELD_W] ? '1 : pp_sum[FIELD_W-1:0];
        end
        if (state_reg == ST_LOAD) begin
            vacc_reg <= '0;
        end else if (state_reg == ST_RUN) begin
            vacc_reg <= (vacc_reg << 1) + (q_bit ? VACC_W'(pp_reg) : '0);
        end
        if (lane_ctrl.commit) begin
            m_tdata_reg <= est_bus;
        end
    end

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready while an item is in progress");

    a_variance_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_ctrl.commit |=> variance_reg <= $past(pp_reg))
        else $error("variance grew past its prediction");

    a_first_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !first_pending_reg)
        else $error("first item flag still set after a transfer");

    a_result_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_ctrl.commit |=> (m_tvalid_reg && state_reg == ST_IDLE))
        else $error("finished item did not reach the output register");

endmodule
